[src/splh_pkg.sv]
// ----------------------------------------------------------------------------
// splh_pkg
// Shared constants, request structs and sequencer states for the simple
// path length histogram.
// ----------------------------------------------------------------------------
package splh_pkg;

	localparam int MAX_STATES      = 64;
	localparam int SLOTS_PER_STATE = 8;
	localparam int STATE_W         = $clog2(MAX_STATES);
	localparam int SLOT_W          = $clog2(SLOTS_PER_STATE);
	localparam int SLOTK_W         = $clog2(SLOTS_PER_STATE + 1);
	localparam int EDGE_DEPTH      = MAX_STATES * SLOTS_PER_STATE;
	localparam int EDGE_AW         = $clog2(EDGE_DEPTH);
	localparam int SUCC_W          = 7;
	localparam int SIN_W           = 7;
	localparam int SP_W            = $clog2(MAX_STATES + 1);
	localparam int CNT_W           = 64;
	localparam int STK_W           = STATE_W + SLOTK_W;

	localparam logic [SIN_W-1:0]   SIN_RESET = SIN_W'(41);
	localparam logic [SUCC_W-1:0]  NO_EDGE   = '1;
	localparam logic [SLOTK_W-1:0] SLOT_END  = SLOTK_W'(SLOTS_PER_STATE);
	localparam logic [SP_W-1:0]    SP_MAX    = SP_W'(MAX_STATES);

	typedef struct packed {
		logic               we;
		logic [EDGE_AW-1:0] waddr;
		logic [SUCC_W-1:0]  wdata;
		logic [EDGE_AW-1:0] raddr;
	} edge_req_t;

	typedef struct packed {
		logic               we;
		logic [STATE_W-1:0] waddr;
		logic [STK_W-1:0]   wdata;
		logic [STATE_W-1:0] raddr;
	} stk_req_t;

	typedef struct packed {
		logic               we;
		logic [STATE_W-1:0] waddr;
		logic [CNT_W-1:0]   wdata;
		logic [STATE_W-1:0] raddr;
	} cnt_req_t;

	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_RD    = 8'b0000_0100,
		ST_POPW  = 8'b0000_1000,
		ST_EV    = 8'b0001_0000,
		ST_INC   = 8'b0010_0000,
		ST_ORD   = 8'b0100_0000,
		ST_OWAIT = 8'b1000_0000
	} st_t;

endpackage

[src/splh_ram.sv]
// ----------------------------------------------------------------------------
// splh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module splh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/splh_ctrl.sv]
// ----------------------------------------------------------------------------
// splh_ctrl
// Walk sequencer: table load, clearing pass, depth-first enumeration over
// the edge, stack and count memories, and the result register.
// ----------------------------------------------------------------------------
module splh_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [splh_pkg::STATE_W-1:0]         from_state,
	input  logic [splh_pkg::SLOT_W-1:0]          slot,
	input  logic signed [splh_pkg::SUCC_W-1:0]   successor,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [splh_pkg::SIN_W-1:0]           states_in_use,
	output splh_pkg::edge_req_t                  edge_req,
	input  logic [splh_pkg::SUCC_W-1:0]          edge_rdata,
	output splh_pkg::stk_req_t                   stk_req,
	input  logic [splh_pkg::STK_W-1:0]           stk_rdata,
	output splh_pkg::cnt_req_t                   cnt_req,
	input  logic [splh_pkg::CNT_W-1:0]           cnt_rdata,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [splh_pkg::STATE_W-1:0]         depth,
	output logic [splh_pkg::CNT_W-1:0]           paths_at_depth,
	output logic [splh_pkg::CNT_W-1:0]           total_paths,
	output logic                                 last
);

	import splh_pkg::*;

	st_t                 st_q;
	logic [EDGE_AW-1:0]  clr_q;
	logic [SIN_W-1:0]    sin_q;
	logic [SP_W-1:0]     sp_q;
	logic [STATE_W-1:0]  k_q;
	logic [MAX_STATES-1:0] visited_q;
	logic [MAX_STATES-1:0] dvalid_q;
	logic                out_valid_q;

	logic [STATE_W-1:0]  cur_s_q;
	logic [SLOTK_W-1:0]  cur_k_q;
	logic [SP_W-1:0]     n_q;
	logic [CNT_W-1:0]    total_q;
	logic [STATE_W-1:0]  inc_addr_q;
	logic [STATE_W-1:0]  out_depth_q;
	logic [CNT_W-1:0]    out_paths_q;
	logic [CNT_W-1:0]    out_total_q;
	logic                out_last_q;

	logic                in_acc;
	logic                out_acc;
	logic                start;
	logic                take;
	logic                out_free;
	logic                k_last;
	logic [SP_W-1:0]     n_run;
	logic [CNT_W-1:0]    cnt_old;
	logic [CNT_W-1:0]    cnt_out;

	assign in_stall  = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid & ~in_stall;
	assign out_acc   = out_valid_q & ~out_stall;
	assign start     = in_acc & op;
	assign out_free  = ~out_valid_q | out_acc;
	assign k_last    = ((SP_W'(k_q) + SP_W'(1)) == n_q);

	always_comb begin
		if (sin_q == '0) begin
			n_run = SP_W'(1);
		end else if (SP_W'(sin_q) > SP_MAX) begin
			n_run = SP_MAX;
		end else begin
			n_run = SP_W'(sin_q);
		end
	end

	// successor is usable: non-negative, inside the run, unvisited, room on the stack
	assign take = (st_q == ST_EV) & ~edge_rdata[SUCC_W-1]
		& (SP_W'(edge_rdata[SUCC_W-2:0]) < n_q)
		& ~visited_q[edge_rdata[STATE_W-1:0]]
		& (sp_q < SP_MAX);

	assign cnt_old = dvalid_q[inc_addr_q] ? cnt_rdata : '0;
	assign cnt_out = dvalid_q[k_q] ? cnt_rdata : '0;

	always_comb begin
		edge_req.we    = (st_q == ST_CLR) | (in_acc & ~op);
		edge_req.waddr = (st_q == ST_CLR) ? clr_q : {from_state, slot};
		edge_req.wdata = (st_q == ST_CLR) ? NO_EDGE : successor;
		edge_req.raddr = {cur_s_q, cur_k_q[SLOT_W-1:0]};

		stk_req.we     = take;
		stk_req.waddr  = STATE_W'(sp_q - SP_W'(1));
		stk_req.wdata  = {cur_s_q, cur_k_q};
		stk_req.raddr  = STATE_W'(sp_q - SP_W'(2));

		cnt_req.we     = start | (st_q == ST_INC);
		cnt_req.waddr  = start ? '0 : inc_addr_q;
		cnt_req.wdata  = start ? CNT_W'(1) : cnt_old + CNT_W'(1);
		cnt_req.raddr  = (st_q == ST_ORD) ? k_q : sp_q[STATE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_q       <= '0;
			sin_q       <= SIN_RESET;
			sp_q        <= '0;
			k_q         <= '0;
			visited_q   <= '0;
			dvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sin_q <= states_in_use;
			end
			if (st_q == ST_OWAIT) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + EDGE_AW'(1);
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						visited_q <= MAX_STATES'(1);
						dvalid_q  <= MAX_STATES'(1);
						sp_q      <= SP_W'(1);
						st_q      <= ST_RD;
					end
				end
				ST_RD: begin
					if (cur_k_q == SLOT_END) begin
						visited_q[cur_s_q] <= 1'b0;
						sp_q               <= sp_q - SP_W'(1);
						if (sp_q == SP_W'(1)) begin
							k_q  <= '0;
							st_q <= ST_ORD;
						end else begin
							st_q <= ST_POPW;
						end
					end else begin
						st_q <= ST_EV;
					end
				end
				ST_POPW: begin
					st_q <= ST_RD;
				end
				ST_EV: begin
					if (take) begin
						visited_q[edge_rdata[STATE_W-1:0]] <= 1'b1;
						sp_q <= sp_q + SP_W'(1);
						st_q <= ST_INC;
					end else begin
						st_q <= ST_RD;
					end
				end
				ST_INC: begin
					dvalid_q[inc_addr_q] <= 1'b1;
					st_q                 <= ST_RD;
				end
				ST_ORD: begin
					if (out_free) begin
						st_q <= ST_OWAIT;
					end
				end
				ST_OWAIT: begin
					if (k_last) begin
						st_q <= ST_IDLE;
					end else begin
						k_q  <= k_q + STATE_W'(1);
						st_q <= ST_ORD;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (start) begin
					cur_s_q <= '0;
					cur_k_q <= '0;
					n_q     <= n_run;
					total_q <= CNT_W'(1);
				end
			end
			ST_RD: begin
				if (cur_k_q != SLOT_END) begin
					cur_k_q <= cur_k_q + SLOTK_W'(1);
				end
			end
			ST_POPW: begin
				{cur_s_q, cur_k_q} <= stk_rdata;
			end
			ST_EV: begin
				if (take) begin
					inc_addr_q <= sp_q[STATE_W-1:0];
					total_q    <= total_q + CNT_W'(1);
					cur_s_q    <= edge_rdata[STATE_W-1:0];
					cur_k_q    <= '0;
				end
			end
			ST_OWAIT: begin
				out_depth_q <= k_q;
				out_paths_q <= cnt_out;
				out_total_q <= total_q;
				out_last_q  <= k_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign depth          = out_depth_q;
	assign paths_at_depth = out_paths_q;
	assign total_paths    = out_total_q;
	assign last           = out_last_q;

endmodule

[src/simple_path_length_histogram_top.sv]
// ----------------------------------------------------------------------------
// simple_path_length_histogram_top
// Transition table loader and simple-path length histogram over a
// depth-first walk from state 0.
// ----------------------------------------------------------------------------
// After reset the block fills all 512 entries of the edge table with "no
// edge" and holds in_stall high meanwhile; configuration beats are taken at
// any time. A table-write beat is written to the edge table as it is
// accepted. A run walks the successor slots, pushing and popping the stack,
// and then sends the histogram entries; the walk waits on the registered
// reads of the edge table, the stack and the count memory, on which it does
// a read-modify-write per path found. The last result may still wait at the
// output while the next beat is taken.
module simple_path_length_histogram_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [splh_pkg::STATE_W-1:0]         from_state,
	input  logic [splh_pkg::SLOT_W-1:0]          slot,
	input  logic signed [splh_pkg::SUCC_W-1:0]   successor,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [splh_pkg::SIN_W-1:0]           states_in_use,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [splh_pkg::STATE_W-1:0]         depth,
	output logic [splh_pkg::CNT_W-1:0]           paths_at_depth,
	output logic [splh_pkg::CNT_W-1:0]           total_paths,
	output logic                                 last
);

	import splh_pkg::*;

	edge_req_t          edge_req;
	stk_req_t           stk_req;
	cnt_req_t           cnt_req;
	logic [SUCC_W-1:0]  edge_rdata;
	logic [STK_W-1:0]   stk_rdata;
	logic [CNT_W-1:0]   cnt_rdata;

	splh_ram #(.WIDTH(SUCC_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (edge_req.we),
		.waddr (edge_req.waddr),
		.wdata (edge_req.wdata),
		.raddr (edge_req.raddr),
		.rdata (edge_rdata)
	);

	splh_ram #(.WIDTH(STK_W), .DEPTH(MAX_STATES)) u_stk_ram (
		.clk   (clk),
		.we    (stk_req.we),
		.waddr (stk_req.waddr),
		.wdata (stk_req.wdata),
		.raddr (stk_req.raddr),
		.rdata (stk_rdata)
	);

	splh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_STATES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_req.we),
		.waddr (cnt_req.waddr),
		.wdata (cnt_req.wdata),
		.raddr (cnt_req.raddr),
		.rdata (cnt_rdata)
	);

	splh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.from_state     (from_state),
		.slot           (slot),
		.successor      (successor),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.states_in_use  (states_in_use),
		.edge_req       (edge_req),
		.edge_rdata     (edge_rdata),
		.stk_req        (stk_req),
		.stk_rdata      (stk_rdata),
		.cnt_req        (cnt_req),
		.cnt_rdata      (cnt_rdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.depth          (depth),
		.paths_at_depth (paths_at_depth),
		.total_paths    (total_paths),
		.last           (last)
	);

	a_depth0_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (depth == '0) |-> paths_at_depth == CNT_W'(1))
		else $error("depth 0 entry is not the single empty path");

	a_push_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		stk_req.we |-> in_stall)
		else $error("stack written outside a run");

	a_count_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_req.we && !(in_valid && op) |-> in_stall)
		else $error("count memory written outside a run");

	a_part_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> paths_at_depth <= total_paths)
		else $error("depth count exceeds total");

endmodule

[tb/tb_simple_path_length_histogram_top.sv]
// ----------------------------------------------------------------------------
// tb_simple_path_length_histogram_top
// Self-checking bench for the simple path length histogram. A short table of
// directed beats covers reset contents, register extremes, negative and
// out-of-run successors. Random phases follow: each one clears the live
// edges, loads a small random graph, sets the register and starts a run. A
// final phase builds a 64-state chain. Histogram bins are compared with a
// behavioral depth-first walk kept in the bench or with the directed table.
// ----------------------------------------------------------------------------
module tb_simple_path_length_histogram_top;
	timeunit 1ns;
	timeprecision 1ps;
	import splh_pkg::*;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_RUN      = 1'b1;
	localparam int   CYCLE_LIMIT = 2_000_000;
	localparam int   SETTLE      = 16;
	localparam int   HOLD_CYCLES = 400;
	localparam int   MAX_PRINTS  = 40;
	localparam int   DIR_ROWS    = 25;

	typedef enum {ROW_CFG, ROW_WRITE, ROW_RUN} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [STATE_W-1:0]       fs;
		logic [SLOT_W-1:0]        sl;
		logic signed [SUCC_W-1:0] sc;
		logic [SIN_W-1:0]         cfgv;
		bit                       typed;
		int                       exp_len;
		logic [CNT_W-1:0]         exp_total;
		logic [CNT_W-1:0]         exp_d1;
	} row_t;

	typedef struct {
		logic [STATE_W-1:0] depth;
		logic [CNT_W-1:0]   paths;
		logic [CNT_W-1:0]   total;
		logic               last;
	} bin_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     in_valid      = 1'b0;
	logic                     in_stall;
	logic                     op            = 1'b0;
	logic [STATE_W-1:0]       from_state    = '0;
	logic [SLOT_W-1:0]        slot          = '0;
	logic signed [SUCC_W-1:0] successor     = '0;
	logic                     cfg_valid     = 1'b0;
	logic                     cfg_ready;
	logic [SIN_W-1:0]         states_in_use = '0;
	logic                     out_valid;
	logic                     out_stall     = 1'b0;
	logic [STATE_W-1:0]       depth;
	logic [CNT_W-1:0]         paths_at_depth;
	logic [CNT_W-1:0]         total_paths;
	logic                     last;

	simple_path_length_histogram_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.from_state     (from_state),
		.slot           (slot),
		.successor      (successor),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.states_in_use  (states_in_use),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.depth          (depth),
		.paths_at_depth (paths_at_depth),
		.total_paths    (total_paths),
		.last           (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bench copy of the block state
	logic signed [SUCC_W-1:0] edge_mirror [MAX_STATES][SLOTS_PER_STATE];
	logic [SIN_W-1:0]         sin_mirror;
	logic [CNT_W-1:0]         depth_tally [MAX_STATES];
	logic [CNT_W-1:0]         tally_total;
	bin_t                     pending_bins [$];

	row_t dir_tab [DIR_ROWS];

	int   snd_idle     = 28;
	int   rcv_idle     = 65;
	int   beats        = 0;
	int   runs         = 0;
	int   cfg_writes   = 0;
	int   bins_checked = 0;
	int   errors       = 0;
	int   cycles       = 0;
	int   hold_left    = 0;
	bit   hold_done    = 1'b0;
	logic hold_go      = 1'b0;

	int   w, m, r, phase, i, j, tmp;
	int   perm [MAX_STATES];
	int   chain_slot [MAX_STATES];
	logic signed [SUCC_W-1:0] sc;
	logic [SIN_W-1:0]         nsel;

	task automatic log_error(input string msg);
		if (errors < MAX_PRINTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// depth-first walk over simple paths from state 0
	function automatic void enumerate_paths(input int n);
		int stk_state [MAX_STATES];
		int stk_slot [MAX_STATES];
		bit on_path [MAX_STATES];
		int sp, s, k, nx;
		for (int q = 0; q < MAX_STATES; q++) begin
			depth_tally[q] = '0;
			on_path[q]     = 1'b0;
		end
		on_path[0]     = 1'b1;
		tally_total    = CNT_W'(1);
		depth_tally[0] = CNT_W'(1);
		stk_state[0]   = 0;
		stk_slot[0]    = 0;
		sp             = 1;
		while (sp > 0) begin
			s = stk_state[sp-1];
			k = stk_slot[sp-1];
			if (k >= SLOTS_PER_STATE) begin
				on_path[s] = 1'b0;
				sp--;
			end else begin
				stk_slot[sp-1] = k + 1;
				nx = edge_mirror[s][k];
				if (nx >= 0 && nx < n && !on_path[nx] && sp < MAX_STATES) begin
					on_path[nx] = 1'b1;
					tally_total = tally_total + 1;
					depth_tally[sp] = depth_tally[sp] + 1;
					stk_state[sp] = nx;
					stk_slot[sp] = 0;
					sp++;
				end
			end
		end
	endfunction

	task automatic send_item(input logic o, input logic [STATE_W-1:0] f,
			input logic [SLOT_W-1:0] s, input logic signed [SUCC_W-1:0] v,
			input bit predict);
		int n;
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid   <= 1'b1;
		op         <= o;
		from_state <= f;
		slot       <= s;
		successor  <= v;
		do @(posedge clk); while (in_stall);
		beats++;
		if (o == OP_WRITE) begin
			edge_mirror[f][s] = v;
		end else begin
			runs++;
			if (predict) begin
				if (sin_mirror == '0)
					n = 1;
				else if (sin_mirror > SIN_W'(MAX_STATES))
					n = MAX_STATES;
				else
					n = int'(sin_mirror);
				enumerate_paths(n);
				for (int d = 0; d < n; d++)
					pending_bins.push_back('{STATE_W'(d), depth_tally[d], tally_total,
						d == n - 1});
			end
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_bins.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [SIN_W-1:0] v);
		cfg_valid     <= 1'b1;
		states_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		sin_mirror = v;
		cfg_writes++;
	endtask

	// retire every live edge so each phase starts from an empty graph
	task automatic clear_edges();
		for (int f = 0; f < MAX_STATES; f++)
			for (int s = 0; s < SLOTS_PER_STATE; s++)
				if (edge_mirror[f][s] >= 0)
					send_item(OP_WRITE, STATE_W'(f), SLOT_W'(s),
						SUCC_W'(-int'($urandom_range(1, 64))), 1'b0);
	endtask

	// output side: check each accepted beat, then pick next stall
	always @(posedge clk) begin : bin_check
		bin_t want;
		if (arst_n && out_valid && !out_stall) begin
			bins_checked++;
			if (pending_bins.size() == 0) begin
				log_error($sformatf("unexpected bin depth %0d paths %0d", depth,
					paths_at_depth));
			end else begin
				want = pending_bins.pop_front();
				if (depth !== want.depth)
					log_error($sformatf("depth: got %0d want %0d", depth, want.depth));
				if (paths_at_depth !== want.paths)
					log_error($sformatf("paths_at_depth (depth %0d): got %0d want %0d",
						want.depth, paths_at_depth, want.paths));
				if (total_paths !== want.total)
					log_error($sformatf("total_paths (depth %0d): got %0d want %0d",
						want.depth, total_paths, want.total));
				if (last !== want.last)
					log_error($sformatf("last (depth %0d): got %0b want %0b",
						want.depth, last, want.last));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		for (int f = 0; f < MAX_STATES; f++)
			for (int s = 0; s < SLOTS_PER_STATE; s++)
				edge_mirror[f][s] = NO_EDGE;
		sin_mirror = SIN_RESET;

		// kind, from, slot, succ, cfg, typed, bins, total, count at depth 1
		dir_tab = '{
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b1, 41, 64'd1, 64'd0},
			'{ROW_WRITE, 6'd0,  3'd0, 7'sd63,         7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd0,  3'd7, 7'sd5,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd0,  3'd3, SUCC_W'(-64),   7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd0,  3'd1, 7'sd0,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_CFG,   6'd0,  3'd0, 7'sd0,          7'd127, 1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b1, 64, 64'd3, 64'd2},
			'{ROW_CFG,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b1, 1,  64'd1, 64'd0},
			'{ROW_CFG,   6'd0,  3'd0, 7'sd0,          7'd6,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b1, 6,  64'd2, 64'd1},
			'{ROW_WRITE, 6'd5,  3'd2, 7'sd1,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd1,  3'd4, 7'sd5,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd1,  3'd0, 7'sd2,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd2,  3'd7, 7'sd0,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd63, 3'd7, SUCC_W'(-1),    7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd0,  3'd7, SUCC_W'(-1),    7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_WRITE, 6'd0,  3'd2, 7'sd1,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_CFG,   6'd0,  3'd0, 7'sd0,          7'd64,  1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_CFG,   6'd0,  3'd0, 7'sd0,          7'd1,   1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b1, 1,  64'd1, 64'd0},
			'{ROW_CFG,   6'd0,  3'd0, 7'sd0,          7'd65,  1'b0, 0,  64'd0, 64'd0},
			'{ROW_RUN,   6'd0,  3'd0, 7'sd0,          7'd0,   1'b0, 0,  64'd0, 64'd0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k]) begin
			case (dir_tab[k].kind)
			ROW_CFG: begin
				wait_idle();
				write_cfg(dir_tab[k].cfgv);
			end
			ROW_WRITE: begin
				send_item(OP_WRITE, dir_tab[k].fs, dir_tab[k].sl, dir_tab[k].sc, 1'b0);
			end
			default: begin
				if (dir_tab[k].typed)
					for (int d = 0; d < dir_tab[k].exp_len; d++)
						pending_bins.push_back('{STATE_W'(d),
							(d == 0) ? CNT_W'(1) : (d == 1) ? dir_tab[k].exp_d1 : CNT_W'(0),
							dir_tab[k].exp_total, d == dir_tab[k].exp_len - 1});
				send_item(OP_RUN, STATE_W'($urandom), SLOT_W'($urandom), SUCC_W'($urandom),
					!dir_tab[k].typed);
			end
			endcase
		end

		// random phases: small window graph plus dead-end and dropped edges
		phase = 0;
		while (beats < 110) begin
			if (beats < 60) begin
				snd_idle = 28;
				rcv_idle = 65;
			end else if (beats < 95) begin
				snd_idle = 65;
				rcv_idle = 28;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			clear_edges();
			w = $urandom_range(2, 7);
			m = $urandom_range(3, 14);
			repeat (m) begin
				r = $urandom_range(99);
				if (r < 70)
					sc = SUCC_W'($urandom_range(0, w - 1));
				else if (r < 85)
					sc = SUCC_W'($urandom_range(w, 63));
				else
					sc = SUCC_W'(-int'($urandom_range(1, 64)));
				send_item(OP_WRITE, STATE_W'($urandom_range(0, w - 1)),
					SLOT_W'($urandom_range(0, 7)), sc, 1'b0);
			end
			repeat ($urandom_range(0, 2))
				send_item(OP_WRITE, STATE_W'($urandom_range(w, 63)),
					SLOT_W'($urandom_range(0, 7)), SUCC_W'(-int'($urandom_range(1, 64))),
					1'b0);
			wait_idle();
			r = $urandom_range(9);
			if (phase == 2 || r == 2)
				nsel = SIN_W'(MAX_STATES);
			else if (r == 0)
				nsel = '0;
			else if (r == 1)
				nsel = SIN_W'($urandom_range(65, 127));
			else if (r == 3)
				nsel = SIN_W'($urandom_range(1, 64));
			else
				nsel = SIN_W'($urandom_range(w - 1, w + 1));
			write_cfg(nsel);
			// long output hold-off; following beats back up into the block
			if (phase == 2)
				hold_go <= 1'b1;
			send_item(OP_RUN, STATE_W'($urandom), SLOT_W'($urandom), SUCC_W'($urandom),
				1'b1);
			phase++;
		end

		// chain through all states in random order, plus back edges
		snd_idle = 0;
		rcv_idle = 0;
		clear_edges();
		for (int q = 0; q < MAX_STATES; q++)
			perm[q] = q;
		for (i = MAX_STATES - 1; i > 1; i--) begin
			j = $urandom_range(1, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (i = 0; i < MAX_STATES - 1; i++) begin
			chain_slot[perm[i]] = $urandom_range(0, 7);
			send_item(OP_WRITE, STATE_W'(perm[i]), SLOT_W'(chain_slot[perm[i]]),
				SUCC_W'(perm[i+1]), 1'b0);
		end
		repeat (6) begin
			i = $urandom_range(1, MAX_STATES - 2);
			j = $urandom_range(0, i - 1);
			send_item(OP_WRITE, STATE_W'(perm[i]),
				SLOT_W'(chain_slot[perm[i]] + $urandom_range(1, 7)), SUCC_W'(perm[j]), 1'b0);
		end
		for (int c = 0; c < 4; c++) begin
			wait_idle();
			if (c == 0)
				write_cfg(SIN_W'(MAX_STATES));
			else if (c == 1)
				write_cfg(SIN_W'(127));
			else if (c == 2)
				write_cfg('0);
			else
				write_cfg(SIN_W'($urandom_range(2, 63)));
			send_item(OP_RUN, STATE_W'($urandom), SLOT_W'($urandom), SUCC_W'($urandom),
				1'b1);
		end

		wait_idle();
		$display("Run summary: %0d input beats, %0d enumeration runs, %0d register writes,",
			beats, runs, cfg_writes);
		$display("  %0d histogram bins checked over cleared, sparse, dense and chain graphs.",
			bins_checked);
		if (errors == 0 && pending_bins.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[simple_path_length_histogram_top.f]
src/splh_pkg.sv
src/splh_ram.sv
src/splh_ctrl.sv
src/simple_path_length_histogram_top.sv
tb/tb_simple_path_length_histogram_top.sv
